// ===== rtl/core/vfcs_pkg.sv =====
package vfcs_pkg;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [63:0] bin_value;
        logic [31:0] bin_count;
        logic        last_bin;
        logic        table_empty;
        logic        overflowed;
    } t_out_item;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SRD  = 8'b0000_0010,
        S_SCMP = 8'b0000_0100,
        S_INS  = 8'b0000_1000,
        S_FRD  = 8'b0001_0000,
        S_FCMP = 8'b0010_0000,
        S_VRD  = 8'b0100_0000,
        S_VLD  = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/core/vfcs_table.sv =====
module vfcs_table #(
    parameter int DEPTH = 64,
    parameter int CW    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_val_en,
    input  logic                     i_wr_cnt_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [63:0]              i_wr_val,
    input  logic [CW-1:0]            i_wr_cnt,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [63:0]              o_rd_val,
    output logic [CW-1:0]            o_rd_cnt
);
    logic [63:0]   r_vals [DEPTH];
    logic [CW-1:0] r_cnts [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_val_en) begin
            r_vals[i_wr_addr] <= i_wr_val;
        end
        o_rd_val <= r_vals[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt_en) begin
            r_cnts[i_wr_addr] <= i_wr_cnt;
        end
        o_rd_cnt <= r_cnts[i_rd_addr];
    end

endmodule

// ===== rtl/core/value_frequency_count_sorted_top.sv =====
// Frequency histogram of 64-bit sample values with a descending-count readout.
// Input channel (i_in_valid / o_in_ready / i_in_data): an add item counts its
// sample_value; a finish item reads out every stored entry, highest count
// first, equal counts in order of first appearance, then empties the table.
// Output channel (o_out_valid / i_out_ready / o_out_data): one item per entry,
// last_bin on the final one; an empty table gives one item with table_empty.
// The block takes one input item at a time and is not ready while working.
// An add item compares the stored entries one at a time through the single
// table read port, then increments the matching count or, if there is room,
// writes a new entry with count 1; a new value for a full table is dropped.
// A finish item finds each result by a full scan of the stored counts, then
// reads its value and offers it on the output channel.
// While the receiver stalls, the held result stays on o_out_data and the scan
// waits. Reset empties the table and clears the overflow flag; the table
// memory itself is not cleared, as only entries in use are ever read.
module value_frequency_count_sorted_top #(
    parameter int TABLE_DEPTH = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vfcs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vfcs_pkg::t_out_item o_out_data
);
    import vfcs_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int UW = $clog2(TABLE_DEPTH + 1);

    t_state                 r_state, n_state;
    logic [UW-1:0]          r_used, n_used;
    logic                   r_drop, n_drop;
    logic [IW-1:0]          r_idx, n_idx;
    logic [63:0]            r_sample, n_sample;
    logic                   r_first, n_first;
    logic                   r_have, n_have;
    logic [COUNT_WIDTH-1:0] r_best_cnt, n_best_cnt;
    logic [IW-1:0]          r_best_idx, n_best_idx;
    logic [COUNT_WIDTH-1:0] r_prev_cnt, n_prev_cnt;
    logic [IW-1:0]          r_prev_idx, n_prev_idx;
    logic [UW-1:0]          r_emitted, n_emitted;
    logic                   r_out_valid, n_out_valid;
    logic                   r_final, n_final;
    t_out_item              r_out, n_out;

    logic                   wr_val_en, wr_cnt_en;
    logic [IW-1:0]          wr_addr, rd_addr;
    logic [COUNT_WIDTH-1:0] wr_cnt;
    logic [63:0]            rd_val;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic                   at_end, eligible;

    vfcs_table #(
        .DEPTH (TABLE_DEPTH),
        .CW    (COUNT_WIDTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_val_en (wr_val_en),
        .i_wr_cnt_en (wr_cnt_en),
        .i_wr_addr   (wr_addr),
        .i_wr_val    (r_sample),
        .i_wr_cnt    (wr_cnt),
        .i_rd_addr   (rd_addr),
        .o_rd_val    (rd_val),
        .o_rd_cnt    (rd_cnt)
    );

    assign rd_addr  = (r_state == S_VRD) ? r_best_idx : r_idx;
    assign at_end   = ((UW'(r_idx) + UW'(1)) == r_used);
    // Entries already emitted rank at or above the previous result.
    assign eligible = r_first || (rd_cnt < r_prev_cnt)
                      || ((rd_cnt == r_prev_cnt) && (r_idx > r_prev_idx));

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_drop      = r_drop;
        n_idx       = r_idx;
        n_sample    = r_sample;
        n_first     = r_first;
        n_have      = r_have;
        n_best_cnt  = r_best_cnt;
        n_best_idx  = r_best_idx;
        n_prev_cnt  = r_prev_cnt;
        n_prev_idx  = r_prev_idx;
        n_emitted   = r_emitted;
        n_out_valid = r_out_valid;
        n_final     = r_final;
        n_out       = r_out;
        wr_val_en   = 1'b0;
        wr_cnt_en   = 1'b0;
        wr_addr     = r_idx;
        wr_cnt      = rd_cnt;

        unique case (r_state)
            S_IDLE: begin
                if (r_out_valid) begin
                    if (i_out_ready) begin
                        n_out_valid = 1'b0;
                        if (r_final) begin
                            n_used = '0;
                            n_drop = 1'b0;
                        end else begin
                            n_prev_cnt = r_best_cnt;
                            n_prev_idx = r_best_idx;
                            n_first    = 1'b0;
                            n_have     = 1'b0;
                            n_emitted  = r_emitted + UW'(1);
                            n_idx      = '0;
                            n_state    = S_FRD;
                        end
                    end
                end else if (i_in_valid) begin
                    n_sample = i_in_data.sample_value;
                    n_idx    = '0;
                    if (i_in_data.req_type == REQ_ADD) begin
                        n_state = (r_used == '0) ? S_INS : S_SRD;
                    end else if (r_used == '0) begin
                        n_out             = '0;
                        n_out.table_empty = 1'b1;
                        n_out_valid       = 1'b1;
                        n_final           = 1'b1;
                    end else begin
                        n_first   = 1'b1;
                        n_have    = 1'b0;
                        n_emitted = '0;
                        n_state   = S_FRD;
                    end
                end
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (rd_val == r_sample) begin
                    wr_cnt_en = 1'b1;
                    wr_cnt    = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);
                    n_state   = S_IDLE;
                end else if (at_end) begin
                    n_state = S_INS;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SRD;
                end
            end
            S_INS: begin
                if (r_used == UW'(TABLE_DEPTH)) begin
                    n_drop = 1'b1;
                end else begin
                    wr_val_en = 1'b1;
                    wr_cnt_en = 1'b1;
                    wr_addr   = IW'(r_used);
                    wr_cnt    = COUNT_WIDTH'(1);
                    n_used    = r_used + UW'(1);
                end
                n_state = S_IDLE;
            end
            S_FRD: begin
                n_state = S_FCMP;
            end
            S_FCMP: begin
                // Strictly greater keeps the earliest entry among equal counts.
                if (eligible && (!r_have || (rd_cnt > r_best_cnt))) begin
                    n_have     = 1'b1;
                    n_best_cnt = rd_cnt;
                    n_best_idx = r_idx;
                end
                if (at_end) begin
                    n_state = S_VRD;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_FRD;
                end
            end
            S_VRD: begin
                n_state = S_VLD;
            end
            S_VLD: begin
                n_final             = ((r_emitted + UW'(1)) == r_used);
                n_out.bin_value     = rd_val;
                n_out.bin_count     = 32'(r_best_cnt);
                n_out.last_bin      = n_final;
                n_out.table_empty   = 1'b0;
                n_out.overflowed    = r_drop;
                n_out_valid         = 1'b1;
                n_state             = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            r_final     <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_sample   <= n_sample;
        r_first    <= n_first;
        r_have     <= n_have;
        r_best_cnt <= n_best_cnt;
        r_best_idx <= n_best_idx;
        r_prev_cnt <= n_prev_cnt;
        r_prev_idx <= n_prev_idx;
        r_emitted  <= n_emitted;
        r_out      <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is pending");

    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.table_empty) |->
            (!o_out_data.last_bin && (o_out_data.bin_count == 32'd0)))
        else $error("empty marker carries data");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && r_final) |=> (r_used == '0) && !r_drop)
        else $error("table not cleared after the last result");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import vfcs_pkg::*;

    localparam int DEPTH      = 64;
    localparam int ADD_CYCLES = 2 * DEPTH + 2;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    int        mismatches;
    int        items_sent;

    value_frequency_count_sorted_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    task automatic report(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    class histogram_scoreboard;
        logic [63:0] hist_values[DEPTH];
        logic [31:0] hist_counts[DEPTH];
        int          used;
        bit          dropped;
        t_out_item   expected_bins[$];

        function void note_input(t_in_item item);
            int        order[DEPTH];
            int        i;
            int        j;
            int        k;
            t_out_item bin;
            if (item.req_type == REQ_ADD) begin
                for (i = 0; i < used; i++) begin
                    if (hist_values[i] == item.sample_value) begin
                        if (hist_counts[i] != '1) hist_counts[i]++;
                        return;
                    end
                end
                if (used < DEPTH) begin
                    hist_values[used] = item.sample_value;
                    hist_counts[used] = 32'd1;
                    used++;
                end else begin
                    dropped = 1'b1;
                end
                return;
            end
            if (used == 0) begin
                bin = '0;
                bin.table_empty = 1'b1;
                expected_bins.push_back(bin);
            end else begin
                // Stable insertion sort: equal counts keep first-appearance order.
                for (i = 0; i < used; i++) begin
                    k = i;
                    j = i;
                    while (j > 0 && hist_counts[order[j - 1]] < hist_counts[k]) begin
                        order[j] = order[j - 1];
                        j--;
                    end
                    order[j] = k;
                end
                for (i = 0; i < used; i++) begin
                    bin.bin_value   = hist_values[order[i]];
                    bin.bin_count   = hist_counts[order[i]];
                    bin.last_bin    = (i == used - 1);
                    bin.table_empty = 1'b0;
                    bin.overflowed  = dropped;
                    expected_bins.push_back(bin);
                end
            end
            used    = 0;
            dropped = 1'b0;
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_bins.size() == 0) begin
                report($sformatf("unexpected result value=%h", got.bin_value));
                return;
            end
            want = expected_bins.pop_front();
            if (got.bin_value != want.bin_value)
                report($sformatf("bin_value %h, want %h", got.bin_value, want.bin_value));
            if (got.bin_count != want.bin_count)
                report($sformatf("bin_count %0d, want %0d", got.bin_count, want.bin_count));
            if (got.last_bin != want.last_bin)
                report($sformatf("last_bin %b, want %b", got.last_bin, want.last_bin));
            if (got.table_empty != want.table_empty)
                report($sformatf("table_empty %b, want %b", got.table_empty, want.table_empty));
            if (got.overflowed != want.overflowed)
                report($sformatf("overflowed %b, want %b", got.overflowed, want.overflowed));
        endtask

        function int pending();
            return expected_bins.size();
        endfunction
    endclass

    histogram_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // Quiet stretches switch idling off on a side for a while.
    function automatic int idle_length(input bit quiet);
        int pick;
        if (quiet) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_input(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    initial begin
        int stall;
        bit quiet;
        i_out_ready = 1'b0;
        stall = 0;
        quiet = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) quiet = ~quiet;
            if (stall > 0) begin
                i_out_ready = 1'b0;
                stall--;
            end else begin
                i_out_ready = 1'b1;
                stall = idle_length(quiet);
            end
        end
    end

    bit send_quiet;

    task automatic send(input logic kind, input logic [63:0] value);
        int gap;
        @(negedge i_clk);
        if ($urandom_range(0, 99) == 0) send_quiet = ~send_quiet;
        gap = idle_length(send_quiet);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid             = 1'b1;
        i_in_data.req_type     = kind;
        i_in_data.sample_value = value;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    function automatic logic [63:0] any_value();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [63:0] pool[8];
        int          batch;
        int          pick;
        int          n;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        mismatches  = 0;
        items_sent  = 0;
        send_quiet  = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, extreme values, repeats and ties, ignored sample.
        send(REQ_FINISH, '0);
        send(REQ_ADD, '0);
        send(REQ_ADD, '1);
        send(REQ_ADD, 64'h8000_0000_0000_0001);
        send(REQ_ADD, '1);
        send(REQ_ADD, 64'h5555_5555_5555_5555);
        send(REQ_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        send(REQ_ADD, '1);
        send(REQ_ADD, '0);
        send(REQ_FINISH, '1);
        send(REQ_FINISH, 64'h1234_5678_9ABC_DEF0);
        send(REQ_ADD, 64'h0000_0000_0000_0001);
        send(REQ_FINISH, '0);

        while (items_sent < 310) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                for (int i = 0; i < 8; i++) pool[i] = any_value();
                batch = $urandom_range(1, 12);
                n = $urandom_range(1, 8);
                for (int i = 0; i < batch; i++) begin
                    if ($urandom_range(0, 4) == 0) send(REQ_ADD, any_value());
                    else send(REQ_ADD, pool[$urandom_range(0, n - 1)]);
                end
                send(REQ_FINISH, any_value());
            end else if (pick < 80) begin
                // Fill the table up to or past its depth so that new values may be dropped.
                batch = $urandom_range(DEPTH - 2, DEPTH + 6);
                for (int i = 0; i < batch; i++) begin
                    if (i > 0 && $urandom_range(0, 5) == 0) send(REQ_ADD, 64'(i / 2));
                    else send(REQ_ADD, 64'(i));
                end
                send(REQ_ADD, 64'd3);
                send(REQ_FINISH, '0);
            end else begin
                send(logic'($urandom_range(0, 1)), any_value());
            end
            if (pick == 5) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (ADD_CYCLES + 20) @(posedge i_clk);
        if (sb.pending() != 0) report("expected results left over");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
